FILE: rtl/bte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bte_pkg;

    // integer bits of a curve coordinate, before the fraction bits
    localparam int COORD_INT_W = 27;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HANDLE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HANDLE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEVEL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HANDLE_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HANDLE_Y   = 3'd7;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // schedule of one de casteljau evaluation on the three-stage lerp unit
    localparam step_t STEP_ISSUE_P01 = 4'd0;
    localparam step_t STEP_ISSUE_P12 = 4'd1;
    localparam step_t STEP_ISSUE_P23 = 4'd2;
    localparam step_t STEP_CAP_A     = 4'd3;
    localparam step_t STEP_CAP_B     = 4'd4;
    localparam step_t STEP_CAP_C     = 4'd5;
    localparam step_t STEP_ISSUE_BC  = 4'd6;
    localparam step_t STEP_CAP_D     = 4'd8;
    localparam step_t STEP_CAP_E     = 4'd9;
    localparam step_t STEP_ISSUE_DE  = 4'd10;
    localparam step_t STEP_LAST      = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EVAL_X,
        ST_CHECK,
        ST_MID,
        ST_LOAD_Y,
        ST_EVAL_Y,
        ST_ROUND
    } state_t;

    typedef enum logic [2:0] {
        OP_P01,
        OP_P12,
        OP_P23,
        OP_AB,
        OP_BC,
        OP_DE
    } lerp_op_t;

    typedef struct packed {
        logic     busy;
        lerp_op_t op;
        logic     cap_a;
        logic     cap_b;
        logic     cap_c;
        logic     cap_d;
        logic     cap_e;
        logic     cap_f;
        logic     prep;
        logic     check;
        logic     mid;
        logic     load_y;
        logic     round;
    } ctrl_t;

    typedef struct packed {
        logic hit;
        logic iter_last;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/bte_lerp.sv
`timescale 1ns / 1ps
`default_nettype none

module bte_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int CW        = 43
) (
    input  wire  logic                   clk,
    input  wire  logic signed [CW-1:0]   a,
    input  wire  logic signed [CW-1:0]   b,
    input  wire  logic [FRAC_BITS:0]     u,
    output logic signed [CW-1:0]         r
);

    localparam int PW = CW + FRAC_BITS + 3;

    logic signed [CW-1:0] a1_reg;
    logic signed [CW:0]   d1_reg;
    logic signed [CW-1:0] a2_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [CW-1:0] r_reg;

    logic signed [CW:0]   d1_next;
    logic signed [PW-1:0] p2_next;
    logic signed [CW-1:0] r_next;

    // r = a + floor((b - a) * u / 2^frac)
    assign d1_next = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    assign p2_next = d1_reg * $signed({1'b0, u});
    assign r_next  = a2_reg + $signed(p2_reg[FRAC_BITS +: CW]);

    always_ff @(posedge clk)
    begin
        a1_reg <= a;
        d1_reg <= d1_next;
        a2_reg <= a1_reg;
        p2_reg <= p2_next;
        r_reg  <= r_next;
    end

    assign r = r_reg;

endmodule

`default_nettype wire

FILE: rtl/bte_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bte_seq (
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  logic              start_go,
    input  wire  bte_pkg::status_t  status,
    output bte_pkg::ctrl_t          ctrl
);

    import bte_pkg::*;

    state_t state_reg;
    state_t state_next;
    step_t  step_reg;
    step_t  step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_go)
                    state_next = ST_PREP;
            end
            ST_PREP:
                state_next = ST_EVAL_X;
            ST_EVAL_X:
            begin
                if (step_reg == STEP_LAST)
                    state_next = ST_CHECK;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_CHECK:
            begin
                if (status.hit)
                    state_next = ST_LOAD_Y;
                else
                    state_next = ST_MID;
            end
            ST_MID:
            begin
                if (status.iter_last)
                    state_next = ST_LOAD_Y;
                else
                    state_next = ST_EVAL_X;
            end
            ST_LOAD_Y:
                state_next = ST_EVAL_Y;
            ST_EVAL_Y:
            begin
                if (step_reg == STEP_LAST)
                    state_next = ST_ROUND;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_ROUND:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        ctrl.op   = OP_P01;
        ctrl.busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_PREP:   ctrl.prep   = 1'b1;
            ST_CHECK:  ctrl.check  = 1'b1;
            ST_MID:    ctrl.mid    = 1'b1;
            ST_LOAD_Y: ctrl.load_y = 1'b1;
            ST_ROUND:  ctrl.round  = 1'b1;
            ST_EVAL_X, ST_EVAL_Y:
            begin
                unique case (step_reg)
                    STEP_ISSUE_P01: ctrl.op = OP_P01;
                    STEP_ISSUE_P12: ctrl.op = OP_P12;
                    STEP_ISSUE_P23: ctrl.op = OP_P23;
                    STEP_CAP_A:     ctrl.cap_a = 1'b1;
                    STEP_CAP_B:     ctrl.cap_b = 1'b1;
                    STEP_CAP_C:
                    begin
                        ctrl.cap_c = 1'b1;
                        ctrl.op    = OP_AB;
                    end
                    STEP_ISSUE_BC:  ctrl.op = OP_BC;
                    STEP_CAP_D:     ctrl.cap_d = 1'b1;
                    STEP_CAP_E:     ctrl.cap_e = 1'b1;
                    STEP_ISSUE_DE:  ctrl.op = OP_DE;
                    STEP_LAST:      ctrl.cap_f = 1'b1;
                    default:        ctrl.op = OP_P01;
                endcase
            end
            default:   ctrl.busy = ctrl.busy;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bezier_timed_curve_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Evaluates a cubic Bezier animation curve at an absolute time in ms. An item is taken at
// a clock edge with start high and busy low; busy then stays high until the result. The
// curve parameter is found by bisection from the previous item's parameter, with each X
// evaluation run as six lerps on one shared three-stage multiply unit and each bisection
// step including the compare and the midpoint, followed by one Y evaluation.
// The done strobe follows the Y evaluation, which starts when a bisection step lands within
// one ms or when the search runs to its cap of ITERATIONS steps, 24 by default. level_out
// and in_progress are valid only in the single cycle that done is high and must be taken
// then; the next item may be started in that same cycle. Configuration writes are taken at
// any edge with cfg_we high and must only be made while busy is low.
module bezier_timed_curve_eval #(
    parameter int ITERATIONS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  wire  logic                                clk,
    input  wire  logic                                rst_n,
    input  wire  logic                                start,
    output logic                                      busy,
    output logic                                      done,
    input  wire  logic [31:0]                         current_time,
    output logic signed [15:0]                        level_out,
    output logic                                      in_progress,
    input  wire  logic                                cfg_we,
    input  wire  logic [bte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  logic [bte_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import bte_pkg::*;

    localparam int CW = COORD_INT_W + FRAC_BITS;
    localparam int UW = FRAC_BITS + 1;
    localparam int IW = $clog2(ITERATIONS);
    localparam int XPAD = COORD_INT_W - 25;
    localparam int LPAD = COORD_INT_W - 14;
    localparam int YPAD = COORD_INT_W - 17;
    localparam int DPAD = COORD_INT_W - 24;

    localparam logic [UW-1:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [CW:0] ONE_D =
        {{(COORD_INT_W){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [CW:0] NEG_ONE_D = -ONE_D;
    localparam logic signed [CW-1:0] HALF_C =
        {{(COORD_INT_W){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [IW-1:0] ITER_LAST = IW'(ITERATIONS - 1);

    ctrl_t   ctrl;
    status_t status;

    // configuration
    logic [31:0]        start_time_reg;
    logic [23:0]        duration_reg;
    logic [13:0]        start_level_reg;
    logic signed [24:0] start_handle_x_reg;
    logic signed [15:0] start_handle_y_reg;
    logic [13:0]        end_level_reg;
    logic signed [24:0] end_handle_x_reg;
    logic signed [15:0] end_handle_y_reg;

    // item state
    logic [31:0]          now_reg;
    logic [23:0]          off_reg;
    logic                 prog_reg;
    logic signed [CW-1:0] pt0_reg, pt1_reg, pt2_reg, pt3_reg;
    logic signed [CW-1:0] la_reg, lb_reg, lc_reg, ld_reg, le_reg, res_reg;
    logic [UW-1:0]        u_reg, lo_reg, hi_reg, last_param_reg;
    logic [IW-1:0]        iter_reg;
    logic signed [15:0]   level_out_reg;
    logic                 in_progress_reg;
    logic                 done_reg;

    // combinational
    logic [32:0]          time_diff;
    logic                 past_end;
    logic [23:0]          off_next;
    logic                 prog_next;
    logic signed [26:0]   x2_int;
    logic signed [16:0]   y1_int, y2_int;
    logic [UW-1:0]        u_init;
    logic signed [CW-1:0] op_a, op_b, lerp_r;
    logic signed [CW-1:0] target;
    logic signed [CW:0]   xdiff;
    logic                 x_above;
    logic [UW-1:0]        mid_next;
    logic signed [CW-1:0] round_sum;
    logic signed [COORD_INT_W-1:0] y_int;
    logic signed [15:0]   level_next;

    bte_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start_go (start && !busy),
        .status   (status),
        .ctrl     (ctrl)
    );

    bte_lerp #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_lerp (
        .clk (clk),
        .a   (op_a),
        .b   (op_b),
        .u   (u_reg),
        .r   (lerp_r)
    );

    always_comb
    begin
        case (ctrl.op)
            OP_P01:  begin op_a = pt0_reg; op_b = pt1_reg; end
            OP_P12:  begin op_a = pt1_reg; op_b = pt2_reg; end
            OP_P23:  begin op_a = pt2_reg; op_b = pt3_reg; end
            OP_AB:   begin op_a = la_reg;  op_b = lb_reg;  end
            OP_BC:   begin op_a = lb_reg;  op_b = lc_reg;  end
            OP_DE:   begin op_a = ld_reg;  op_b = le_reg;  end
            default: begin op_a = pt0_reg; op_b = pt1_reg; end
        endcase
    end

    // offset time, clamped to the curve
    assign time_diff = {1'b0, now_reg} - {1'b0, start_time_reg};
    assign past_end  = (time_diff[31:0] > {8'd0, duration_reg});
    assign prog_next = !time_diff[32] && !past_end;
    assign off_next  = time_diff[32] ? 24'd0 : (past_end ? duration_reg : time_diff[23:0]);

    assign x2_int = $signed({3'b000, duration_reg})
                  + $signed({{2{end_handle_x_reg[24]}}, end_handle_x_reg});
    assign y1_int = $signed({3'b000, start_level_reg})
                  + $signed({start_handle_y_reg[15], start_handle_y_reg});
    assign y2_int = $signed({3'b000, end_level_reg})
                  + $signed({end_handle_y_reg[15], end_handle_y_reg});

    assign u_init = (last_param_reg > ONE_U) ? ONE_U : last_param_reg;

    // bisection compare and midpoint
    assign target   = $signed({{DPAD{1'b0}}, off_reg, {FRAC_BITS{1'b0}}});
    assign xdiff    = $signed({res_reg[CW-1], res_reg}) - $signed({1'b0, target});
    assign x_above  = !xdiff[CW] && (xdiff != '0);
    assign mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign status.hit       = (xdiff < ONE_D) && (xdiff > NEG_ONE_D);
    assign status.iter_last = (iter_reg == ITER_LAST);

    // round half up, then saturate
    assign round_sum = res_reg + HALF_C;
    assign y_int     = round_sum[CW-1:FRAC_BITS];
    always_comb
    begin
        if (y_int[COORD_INT_W-1:15] == '0 || y_int[COORD_INT_W-1:15] == '1)
            level_next = y_int[15:0];
        else if (y_int[COORD_INT_W-1])
            level_next = 16'sh8000;
        else
            level_next = 16'sh7FFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg     <= '0;
            duration_reg       <= '0;
            start_level_reg    <= '0;
            start_handle_x_reg <= '0;
            start_handle_y_reg <= '0;
            end_level_reg      <= '0;
            end_handle_x_reg   <= '0;
            end_handle_y_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_TIME:     start_time_reg     <= cfg_data;
                CFG_DURATION:       duration_reg       <= cfg_data[23:0];
                CFG_START_LEVEL:    start_level_reg    <= cfg_data[13:0];
                CFG_START_HANDLE_X: start_handle_x_reg <= $signed(cfg_data[24:0]);
                CFG_START_HANDLE_Y: start_handle_y_reg <= $signed(cfg_data[15:0]);
                CFG_END_LEVEL:      end_level_reg      <= cfg_data[13:0];
                CFG_END_HANDLE_X:   end_handle_x_reg   <= $signed(cfg_data[24:0]);
                CFG_END_HANDLE_Y:   end_handle_y_reg   <= $signed(cfg_data[15:0]);
                default:            start_time_reg     <= start_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_param_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.round;
            if (ctrl.load_y)
                last_param_reg <= u_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            now_reg <= current_time;

        if (ctrl.prep)
        begin
            off_reg  <= off_next;
            prog_reg <= prog_next;
            pt0_reg  <= '0;
            pt1_reg  <= $signed({{XPAD{start_handle_x_reg[24]}}, start_handle_x_reg,
                                 {FRAC_BITS{1'b0}}});
            pt2_reg  <= $signed({x2_int, {FRAC_BITS{1'b0}}});
            pt3_reg  <= $signed({{DPAD{1'b0}}, duration_reg, {FRAC_BITS{1'b0}}});
            u_reg    <= u_init;
            lo_reg   <= '0;
            hi_reg   <= ONE_U;
            iter_reg <= '0;
        end

        if (ctrl.load_y)
        begin
            pt0_reg <= $signed({{LPAD{1'b0}}, start_level_reg, {FRAC_BITS{1'b0}}});
            pt1_reg <= $signed({{YPAD{y1_int[16]}}, y1_int, {FRAC_BITS{1'b0}}});
            pt2_reg <= $signed({{YPAD{y2_int[16]}}, y2_int, {FRAC_BITS{1'b0}}});
            pt3_reg <= $signed({{LPAD{1'b0}}, end_level_reg, {FRAC_BITS{1'b0}}});
        end

        if (ctrl.cap_a) la_reg  <= lerp_r;
        if (ctrl.cap_b) lb_reg  <= lerp_r;
        if (ctrl.cap_c) lc_reg  <= lerp_r;
        if (ctrl.cap_d) ld_reg  <= lerp_r;
        if (ctrl.cap_e) le_reg  <= lerp_r;
        if (ctrl.cap_f) res_reg <= lerp_r;

        if (ctrl.check && !status.hit)
        begin
            if (x_above)
                hi_reg <= u_reg;
            else
                lo_reg <= u_reg;
        end

        if (ctrl.mid)
        begin
            u_reg    <= mid_next;
            iter_reg <= iter_reg + 1'b1;
        end

        if (ctrl.round)
        begin
            level_out_reg   <= level_next;
            in_progress_reg <= prog_reg;
        end
    end

    assign busy        = ctrl.busy;
    assign done        = done_reg;
    assign level_out   = level_out_reg;
    assign in_progress = in_progress_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_param_reg <= ONE_U)
        else $error("stored curve parameter above one");

endmodule

`default_nettype wire
